/* src/qea_pkg.sv */
// shared types, constants and helpers for the quantized int8 elementwise add core
// no dependencies

package qea_pkg;

   localparam int ByteWidth    = 8;
   localparam int OperandWidth = 8;
   localparam int SumWidth     = 9;
   localparam int MultWidth    = 32;
   localparam int ShiftWidth   = 5;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 32;

   localparam logic signed [31:0] ByteMax = 32'sd127;
   localparam logic signed [31:0] ByteMin = -32'sd128;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FIRST_MULT   = 4'd0,
      CSR_FIRST_SHIFT  = 4'd1,
      CSR_SECOND_MULT  = 4'd2,
      CSR_SECOND_SHIFT = 4'd3,
      CSR_RESULT_MULT  = 4'd4,
      CSR_RESULT_SHIFT = 4'd5,
      CSR_RELU_EN      = 4'd6,
      CSR_REQUANT_EN   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [MultWidth-1:0]  first_multiplier;
      logic [ShiftWidth-1:0]        first_shift;
      logic signed [MultWidth-1:0]  second_multiplier;
      logic [ShiftWidth-1:0]        second_shift;
      logic signed [MultWidth-1:0]  result_multiplier;
      logic [ShiftWidth-1:0]        result_shift;
      logic                         relu_enable;
      logic                         requant_enable;
   } cfg_type;

   // saturate a signed 32-bit value to int8
   function automatic logic signed [ByteWidth-1:0] clamp_byte(
      input logic signed [31:0] value);
      logic signed [ByteWidth-1:0] res;
      if (value > ByteMax) begin
         res = ByteMax[ByteWidth-1:0];
      end else if (value < ByteMin) begin
         res = ByteMin[ByteWidth-1:0];
      end else begin
         res = value[ByteWidth-1:0];
      end
      return res;
   endfunction

endpackage

/* src/qea_csr.sv */
// configuration register file of the quantized int8 elementwise add core
// depends on qea_pkg

module qea_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [qea_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [qea_pkg::CsrDataWidth-1:0]   csr_data,
   output qea_pkg::cfg_type                   cfg
);

   qea_pkg::cfg_type cfg_ff;
   qea_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (qea_pkg::csr_index_type'(csr_index))
            qea_pkg::CSR_FIRST_MULT:   cfg_in.first_multiplier  = signed'(csr_data);
            qea_pkg::CSR_FIRST_SHIFT:  cfg_in.first_shift       =
               csr_data[qea_pkg::ShiftWidth-1:0];
            qea_pkg::CSR_SECOND_MULT:  cfg_in.second_multiplier = signed'(csr_data);
            qea_pkg::CSR_SECOND_SHIFT: cfg_in.second_shift      =
               csr_data[qea_pkg::ShiftWidth-1:0];
            qea_pkg::CSR_RESULT_MULT:  cfg_in.result_multiplier = signed'(csr_data);
            qea_pkg::CSR_RESULT_SHIFT: cfg_in.result_shift      =
               csr_data[qea_pkg::ShiftWidth-1:0];
            qea_pkg::CSR_RELU_EN:      cfg_in.relu_enable       = csr_data[0];
            qea_pkg::CSR_REQUANT_EN:   cfg_in.requant_enable    = csr_data[0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_multiplier  <= 32'sd1;
         cfg_ff.first_shift       <= '0;
         cfg_ff.second_multiplier <= 32'sd1;
         cfg_ff.second_shift      <= '0;
         cfg_ff.result_multiplier <= 32'sd1;
         cfg_ff.result_shift      <= '0;
         cfg_ff.relu_enable       <= 1'b0;
         cfg_ff.requant_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/qea_requant.sv */
// three-stage requantizer: multiply, round and shift, sign restore and clamp
// depends on qea_pkg

module qea_requant #(
   parameter int InWidth = qea_pkg::OperandWidth
) (
   input  logic                                   clock,
   input  logic [2:0]                             stage_en,
   input  logic signed [InWidth-1:0]              in_value,
   input  logic signed [qea_pkg::MultWidth-1:0]   multiplier,
   input  logic [qea_pkg::ShiftWidth-1:0]         shift,
   output logic signed [qea_pkg::ByteWidth-1:0]   out_value
);

   localparam int ProdWidth = InWidth + qea_pkg::MultWidth;

   logic signed [ProdWidth-1:0]         prod_ff, prod_in;
   logic [ProdWidth-1:0]                val_ff, val_in;
   logic                                neg_ff, neg_in;
   logic signed [qea_pkg::ByteWidth-1:0] out_ff, out_in;

   logic                 prod_neg;
   logic                 shift_zero;
   logic [ProdWidth-1:0] mag;
   logic [ProdWidth-1:0] half;
   logic [ProdWidth-1:0] rounded;
   logic [ProdWidth-1:0] signed_val;

   // stage 1: exact product
   assign prod_in = ProdWidth'(in_value) * ProdWidth'(multiplier);

   // stage 2: magnitude rounded half away from zero, then shifted
   always_comb begin
      prod_neg   = prod_ff[ProdWidth-1];
      shift_zero = (shift == '0);
      mag        = prod_neg ? (~prod_ff + ProdWidth'(1)) : prod_ff;
      half       = ProdWidth'(1) << (shift - qea_pkg::ShiftWidth'(1));
      rounded    = (mag + half) >> shift;
      val_in     = shift_zero ? prod_ff : rounded;
      neg_in     = !shift_zero && prod_neg;
   end

   // stage 3: sign back, low 32 bits, saturate
   always_comb begin
      signed_val = neg_ff ? (~val_ff + ProdWidth'(1)) : val_ff;
      out_in     = qea_pkg::clamp_byte(signed'(signed_val[31:0]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[1]) begin
         val_ff <= val_in;
         neg_ff <= neg_in;
      end
      if (stage_en[2]) begin
         out_ff <= out_in;
      end
   end

   assign out_value = out_ff;

endmodule

/* src/int8_quantized_elementwise_add_core.sv */
// top level of the quantized int8 elementwise add core
// depends on qea_pkg, qea_csr and qea_requant

// One element pair enters per clock and one int8 result leaves per clock while the
// output is not stalled, through a seven-stage pipeline: stages 1 to 3 requantize
// both operands in parallel (multiply, round/shift, clamp), stage 4 adds them and
// applies the optional relu and the plain int8 clamp, stages 5 to 7 requantize the
// sum, and stage 7 is the output register. Every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles close up while the
// output stalls and a new word is taken as long as any stage has room. The eight
// configuration registers are written through the csr port, which is always ready;
// write them only while the pipeline holds no word. An index beyond the register
// list is dropped.

module int8_quantized_elementwise_add_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // input words
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [qea_pkg::OperandWidth-1:0] req_first_value,
   input  logic signed [qea_pkg::OperandWidth-1:0] req_second_value,
   input  logic                                    req_last_in,
   // result words
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [qea_pkg::ByteWidth-1:0]    rsp_result_value,
   output logic                                    rsp_last_out,
   // configuration writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [qea_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [qea_pkg::CsrDataWidth-1:0]        csr_data
);

   localparam int Stages = 7;

   qea_pkg::cfg_type cfg;

   // pipeline control
   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages-1:0] stage_ready;

   // last marker rides along with every stage
   logic [Stages-1:0] last_ff;

   // operand results after stage 3
   logic signed [qea_pkg::ByteWidth-1:0] first_q;
   logic signed [qea_pkg::ByteWidth-1:0] second_q;

   // stage 4: sum and the clamp-only result
   logic signed [qea_pkg::SumWidth-1:0]  sum_ff, sum_in;
   logic signed [qea_pkg::SumWidth-1:0]  raw_sum;
   logic signed [qea_pkg::ByteWidth-1:0] sat_ff [3:Stages-1];
   logic signed [qea_pkg::ByteWidth-1:0] sat_in;

   // requantized sum after stage 7
   logic signed [qea_pkg::ByteWidth-1:0] rq_value;

   qea_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // a stage loads when empty or when the next one moves on
   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || rsp_ready;
      for (int k = Stages-2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         last_ff[0] <= req_last_in;
      end
      for (int k = 1; k < Stages; k++) begin
         if (stage_ready[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // stages 1-3: both operands in parallel
   qea_requant #(
      .InWidth (qea_pkg::OperandWidth)
   ) u_first_rq (
      .clock      (clock),
      .stage_en   (stage_ready[2:0]),
      .in_value   (req_first_value),
      .multiplier (cfg.first_multiplier),
      .shift      (cfg.first_shift),
      .out_value  (first_q)
   );

   qea_requant #(
      .InWidth (qea_pkg::OperandWidth)
   ) u_second_rq (
      .clock      (clock),
      .stage_en   (stage_ready[2:0]),
      .in_value   (req_second_value),
      .multiplier (cfg.second_multiplier),
      .shift      (cfg.second_shift),
      .out_value  (second_q)
   );

   // stage 4: add, optional relu, clamp-only path
   always_comb begin
      raw_sum = qea_pkg::SumWidth'(first_q) + qea_pkg::SumWidth'(second_q);
      if (cfg.relu_enable && raw_sum[qea_pkg::SumWidth-1]) begin
         sum_in = '0;
      end else begin
         sum_in = raw_sum;
      end
      sat_in = qea_pkg::clamp_byte(32'(sum_in));
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         sum_ff    <= sum_in;
         sat_ff[3] <= sat_in;
      end
      for (int k = 4; k < Stages; k++) begin
         if (stage_ready[k]) begin
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   // stages 5-7: requantize the sum
   qea_requant #(
      .InWidth (qea_pkg::SumWidth)
   ) u_result_rq (
      .clock      (clock),
      .stage_en   (stage_ready[6:4]),
      .in_value   (sum_ff),
      .multiplier (cfg.result_multiplier),
      .shift      (cfg.result_shift),
      .out_value  (rq_value)
   );

   assign req_ready        = stage_ready[0];
   assign rsp_valid        = valid_ff[Stages-1];
   assign rsp_last_out     = last_ff[Stages-1];
   // the user must keep requant_enable static while words are in flight; not enforced here
   assign rsp_result_value = cfg.requant_enable ? rq_value : sat_ff[Stages-1];

endmodule
